// ===== rtl/rmsn_pkg.sv =====
// Shared widths, constants and controller/datapath interface types for the RMS norm core.
package rmsn_pkg;

  localparam int SUM_W      = 44;  // square sum, Q22.22
  localparam int RMS_W      = 26;  // inverse rms, Q10.16
  localparam int EPS_W      = 30;  // epsilon, Q8.22
  localparam int M_W        = 45;  // mean square plus epsilon
  localparam int Q_W        = 57;  // dividend / quotient width of the divider
  localparam int W_W        = 16;  // weight, Q2.13
  localparam int Y_W        = 16;  // result, Q4.11
  localparam int SQRT_IDX_W = 5;   // bit index of the root search, 25 down to 0
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = EPS_W;

  localparam logic [SUM_W-1:0]      SUM_MAX     = '1;
  localparam logic [RMS_W-1:0]      RMS_MAX     = '1;
  localparam logic [EPS_W-1:0]      EPS_RESET   = 30'd4;
  localparam logic [Q_W-1:0]        RECIP_NUM   = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic [SQRT_IDX_W-1:0] SQRT_TOP    = 5'd25;
  localparam logic [W_W:0]          UNIT_WEIGHT = 17'd8192;

  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_OFFSET = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // latch input beat
    logic square;       // square the sample magnitude
    logic accum;        // add the square into the sum, count it
    logic mean_start;   // start sum/count, clear sum and count
    logic add_eps;      // form mean + epsilon
    logic recip_start;  // start 2^56/m, reset root search
    logic sqrt_step;    // one bit of the root search
    logic rms_load;     // store root as inverse rms
    logic rms_sat;      // store saturated inverse rms
    logic mult;         // sample magnitude times inverse rms
    logic scale;        // times weight magnitude, split in two halves
    logic emit;         // round, saturate, load output register
  } rmsn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic div_done;
    logic m_zero;
    logic sqrt_last;
    logic out_free;
  } rmsn_stat_t;

endpackage

// ===== rtl/rmsn_div.sv =====
// Restoring divider, one quotient bit per cycle.
module rmsn_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [rmsn_pkg::Q_W-1:0] dividend,
  input  logic [rmsn_pkg::M_W-1:0] divisor,
  output logic                    done,
  output logic [rmsn_pkg::Q_W-1:0] quotient
);
  import rmsn_pkg::*;

  localparam int CNT_W = $clog2(Q_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [M_W-1:0]   rem;
  logic [M_W-1:0]   dvs;
  logic [Q_W-1:0]   quo;
  logic [M_W:0]     shifted;
  logic [M_W:0]     diff;
  logic             fits;

  assign shifted = {rem, quo[Q_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
      cnt <= CNT_W'(Q_W - 1);
    end else if (busy) begin
      rem <= fits ? diff[M_W-1:0] : shifted[M_W-1:0];
      quo <= {quo[Q_W-2:0], fits};
      cnt <= cnt - 1'b1;
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/rmsn_datapath.sv =====
// Datapath: sum of squares, mean and reciprocal root, scaling, output register.
module rmsn_datapath #(
  parameter int MAX_DIM      = 4096,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [rmsn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rmsn_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample,
  input  logic signed [rmsn_pkg::W_W-1:0]   weight,
  input  logic                              last,
  input  rmsn_pkg::rmsn_cmd_t               cmd,
  output rmsn_pkg::rmsn_stat_t              stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rmsn_pkg::Y_W-1:0]          y,
  output logic                              last_out
);
  import rmsn_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int CW    = $clog2(MAX_DIM + 1);
  localparam int ADD_W = ((2 * SW > SUM_W) ? 2 * SW : SUM_W) + 1;
  localparam int PW    = SW + RMS_W;
  localparam int HW    = PW - 32 + W_W;
  localparam int MAG_W = ((HW + 3 > 20) ? HW + 3 : 20) + 1;

  // configuration
  logic [EPS_W-1:0] epsilon;
  logic             unit_offset;

  // latched input beat
  logic [SW-1:0]  x_mag;
  logic           x_neg;
  logic [W_W-1:0] w_mag;
  logic           w_neg;
  logic           last_flag;

  // state
  logic [SUM_W-1:0] square_sum;
  logic [CW-1:0]    element_count;
  logic [RMS_W-1:0] inverse_rms;

  // working registers
  logic [2*SW-1:0]       sq;
  logic [M_W-1:0]        m;
  logic [RMS_W-1:0]      root;
  logic [SQRT_IDX_W-1:0] bit_idx;
  logic [PW-1:0]         p1;
  logic [HW-1:0]         hi;
  logic [31+W_W:0]       lo;

  // combinational terms
  logic [SW-1:0]    x_mag_in;
  logic signed [W_W:0] w_eff;
  logic [W_W:0]     w_abs;
  logic [ADD_W-1:0] sum_add;
  logic [RMS_W-1:0] cand;
  logic [RMS_W:0]   t;
  logic [2*RMS_W+1:0] tt;
  logic             div_start;
  logic [Q_W-1:0]   dividend;
  logic [M_W-1:0]   divisor;
  logic             div_done;
  logic [Q_W-1:0]   quotient;
  logic [32+W_W:0]  lo_sum;
  logic [MAG_W-1:0] mag;
  logic [Y_W:0]     mag_sat;
  logic             y_neg;
  logic [Y_W-1:0]   y_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon     <= EPS_RESET;
      unit_offset <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_EPSILON:     epsilon     <= cfg_data[EPS_W-1:0];
        CFG_UNIT_OFFSET: unit_offset <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Split sample and effective weight into sign and magnitude at load.
  assign x_mag_in = sample[SW-1] ? (~sample + 1'b1) : sample;
  assign w_eff    = {weight[W_W-1], weight} + (unit_offset ? $signed(UNIT_WEIGHT) : '0);
  assign w_abs    = w_eff[W_W] ? (~w_eff + 1'b1) : w_eff;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_mag     <= x_mag_in;
      x_neg     <= sample[SW-1];
      w_mag     <= w_abs[W_W-1:0];
      w_neg     <= w_eff[W_W];
      last_flag <= last;
    end
  end

  // Saturating accumulate.
  assign sum_add = ADD_W'(square_sum) + ADD_W'(sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum    <= '0;
      element_count <= '0;
    end else if (cmd.mean_start) begin
      square_sum    <= '0;
      element_count <= '0;
    end else if (cmd.accum && element_count < CW'(MAX_DIM)) begin
      square_sum    <= (sum_add > ADD_W'(SUM_MAX)) ? SUM_MAX : sum_add[SUM_W-1:0];
      element_count <= element_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq <= x_mag * x_mag;
    end
  end

  // Shared divider: sum/count first, then 2^56/m. Count is at least one here.
  assign div_start = cmd.mean_start | cmd.recip_start;
  assign dividend  = cmd.mean_start ? Q_W'(square_sum) : RECIP_NUM;
  assign divisor   = cmd.mean_start ? M_W'(element_count) : m;

  rmsn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.add_eps) begin
      m <= M_W'(quotient[SUM_W-1:0]) + M_W'(epsilon);
    end
  end

  // Root search: largest r with (2r-1)^2 <= quotient, one bit per cycle.
  assign cand = root | (RMS_W'(1) << bit_idx);
  assign t    = {cand, 1'b0} - 1'b1;
  assign tt   = t * t;

  always_ff @(posedge clk) begin
    if (cmd.recip_start) begin
      root    <= '0;
      bit_idx <= SQRT_TOP;
    end else if (cmd.sqrt_step) begin
      if (Q_W'(tt) <= quotient) begin
        root <= cand;
      end
      bit_idx <= bit_idx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_rms <= '0;
    end else if (cmd.rms_sat) begin
      inverse_rms <= RMS_MAX;
    end else if (cmd.rms_load) begin
      inverse_rms <= root;
    end
  end

  // Apply: two registered multiply steps.
  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      p1 <= x_mag * inverse_rms;
    end
    if (cmd.scale) begin
      hi <= p1[PW-1:32] * w_mag;
      lo <= p1[31:0] * w_mag;
    end
  end

  assign lo_sum  = {1'b0, lo} + (49'd1 << 28);
  assign mag     = MAG_W'({hi, 3'b000}) + MAG_W'(lo_sum[48:29]);
  assign y_neg   = x_neg ^ w_neg;

  always_comb begin
    if (y_neg) begin
      mag_sat = (mag > MAG_W'(32768)) ? 17'd32768 : mag[Y_W:0];
      y_next  = ~mag_sat[Y_W-1:0] + 1'b1;
    end else begin
      mag_sat = (mag > MAG_W'(32767)) ? 17'd32767 : mag[Y_W:0];
      y_next  = mag_sat[Y_W-1:0];
    end
  end

  // Output register: hold the beat until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      y        <= y_next;
      last_out <= last_flag;
    end
  end

  assign stat.last      = last_flag;
  assign stat.div_done  = div_done;
  assign stat.m_zero    = (m == '0);
  assign stat.sqrt_last = (bit_idx == '0);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

// ===== rtl/rmsn_ctrl.sv =====
// Controller: sequences accumulate, reciprocal root and apply steps.
module rmsn_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_cmd,
  output logic                 in_ready,
  input  rmsn_pkg::rmsn_stat_t stat,
  output rmsn_pkg::rmsn_cmd_t  cmd
);
  import rmsn_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_ADD_EPS,
    ST_RECIP,
    ST_RECIP_WAIT,
    ST_SQRT,
    ST_RMS_LOAD,
    ST_MULT,
    ST_SCALE,
    ST_EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= in_cmd ? ST_MULT : ST_SQUARE;
          end
        end
        ST_SQUARE:    state <= ST_ACCUM;
        ST_ACCUM:     state <= stat.last ? ST_MEAN : ST_IDLE;
        ST_MEAN:      state <= ST_MEAN_WAIT;
        ST_MEAN_WAIT: begin
          if (stat.div_done) begin
            state <= ST_ADD_EPS;
          end
        end
        ST_ADD_EPS:   state <= ST_RECIP;
        ST_RECIP:     state <= stat.m_zero ? ST_IDLE : ST_RECIP_WAIT;
        ST_RECIP_WAIT: begin
          if (stat.div_done) begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (stat.sqrt_last) begin
            state <= ST_RMS_LOAD;
          end
        end
        ST_RMS_LOAD:  state <= ST_IDLE;
        ST_MULT:      state <= ST_SCALE;
        ST_SCALE:     state <= ST_EMIT;
        ST_EMIT: begin
          if (stat.out_free) begin
            state <= ST_IDLE;
          end
        end
        default:      state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.load        = (state == ST_IDLE) && in_valid;
    cmd.square      = (state == ST_SQUARE);
    cmd.accum       = (state == ST_ACCUM);
    cmd.mean_start  = (state == ST_MEAN);
    cmd.add_eps     = (state == ST_ADD_EPS);
    cmd.recip_start = (state == ST_RECIP) && !stat.m_zero;
    cmd.rms_sat     = (state == ST_RECIP) && stat.m_zero;
    cmd.sqrt_step   = (state == ST_SQRT);
    cmd.rms_load    = (state == ST_RMS_LOAD);
    cmd.mult        = (state == ST_MULT);
    cmd.scale       = (state == ST_SCALE);
    cmd.emit        = (state == ST_EMIT) && stat.out_free;
  end

endmodule

// ===== rtl/rms_norm_two_pass_core.sv =====
// Top level of the two-pass RMS normalization core.
//
//   channel | direction | handshake               | contents
//   --------+-----------+-------------------------+-------------------------------
//   s_*     | in        | s_tvalid / s_tready     | sample, weight, cmd, last
//   m_*     | out       | m_tvalid / m_tready     | y, last_out
//   cfg_*   | in        | cfg_wr_en (no wait)     | epsilon (0), unit_offset (1)
//
// One beat is taken at a time. An accumulate beat steps through latch, square and
// add. The accumulate beat marked last then runs two passes of the shared restoring
// divider with its 57-bit quotient (sum/count, then 2^56/m), 26 root-search steps
// of one 27x27 multiply each, and the loads between them; when the mean square
// plus epsilon is zero, the second divide and the root search are skipped and the
// inverse rms saturates. An apply beat steps through latch, x*rms multiply, weight
// multiply, round and load the output register, and waits in the last of them
// while the output register holds an untaken beat. Reset clears the sum, count,
// inverse rms and the output valid, and loads epsilon = 4, unit_offset = 0.
module rms_norm_two_pass_core #(
  parameter int MAX_DIM      = 4096,
  parameter int SAMPLE_WIDTH = 16,
  localparam int IN_W        = ((SAMPLE_WIDTH + 16 + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_wr_en,
  input  logic [rmsn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rmsn_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [IN_W-1:0]                   s_tdata,  // sample, weight, zero pad
  input  logic [0:0]                        s_tuser,  // cmd
  input  logic                              s_tlast,
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rmsn_pkg::Y_W-1:0]          m_tdata,  // y
  output logic                              m_tlast
);
  import rmsn_pkg::*;

  rmsn_cmd_t  cmd;
  rmsn_stat_t stat;

  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic signed [W_W-1:0]          weight;

  // Unpack the input beat; padding bits are dropped.
  assign sample = s_tdata[SAMPLE_WIDTH-1:0];
  assign weight = s_tdata[SAMPLE_WIDTH+W_W-1:SAMPLE_WIDTH];

  rmsn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_cmd   (s_tuser[0]),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rmsn_datapath #(
    .MAX_DIM      (MAX_DIM),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .weight    (weight),
    .last      (s_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .y         (m_tdata),
    .last_out  (m_tlast)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the two-pass RMS normalization core.
//
// Stimulus runs in two parts. A directed table comes first, walked in order, with
// config writes mixed in between beats:
//   - applies before any inverse rms exists
//   - sample and weight extremes
//   - a zero mean square with zero epsilon
//   - unit-offset weights, including the weight that cancels to zero
//   - the largest epsilon
// Random vectors follow. Each is an accumulate pass, then an apply pass over the
// same samples. Noise beats and apply passes of the wrong length are mixed in.
// The random part runs under three idle patterns, with config changes between
// phases.
// A local predictor tracks the square sum, the element count, the inverse rms and
// both registers. It queues the y and last of every accepted apply beat, and the
// output side pops and compares each beat it takes.
module tb;

  import rmsn_pkg::*;

  localparam int          MAX_DIM       = 4096;
  localparam int          SETTLE_CYCLES = 200;      // longest accumulate-last beat plus margin
  localparam int          CYCLE_LIMIT   = 2000000;
  localparam int          MODE_BEATS    = 580;      // random beats per idle pattern
  localparam logic        CMD_ACCUM     = 1'b0;
  localparam logic        CMD_APPLY     = 1'b1;

  // One output beat as the predictor sees it.
  typedef struct packed {
    logic [Y_W-1:0] y;
    logic           last;
  } norm_beat_t;

  // One row of the directed table: a register write or an input beat.
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  cmd;
    logic [15:0]           x;
    logic [15:0]           w;
    logic                  last;
    logic                  pinned;    // the row carries a typed-in result
    logic [Y_W-1:0]        pinned_y;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;   // sample, weight
  logic [0:0]            s_tuser = '0;   // cmd
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [Y_W-1:0]        m_tdata;        // y
  logic                  m_tlast;

  // Predictor state: a mirror of the core's registers and accumulators.
  logic [43:0]           sum_sq = '0;
  logic [12:0]           n_elems = '0;
  logic [25:0]           inv_rms = '0;
  logic [29:0]           eps_reg = EPS_RESET;
  logic                  unit_off = 1'b0;

  norm_beat_t            pending_y[$];
  norm_beat_t            seen_want;
  plan_row_t             plan[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int vectors_done = 0;
  int reg_writes = 0;
  int errors = 0;
  int cycles = 0;

  rms_norm_two_pass_core #(.MAX_DIM(MAX_DIM), .SAMPLE_WIDTH(16)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Kill a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // round(2^27 / sqrt(m)) by a bitwise root search on 2^56/m; saturate when m is zero.
  function automatic logic [25:0] recip_root(input logic [63:0] m);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] c;
    logic [63:0] t;
    if (m == 64'd0) return '1;
    q = (64'd1 << 56) / m;
    r = '0;
    for (int b = 25; b >= 0; b--) begin
      c = r | (64'd1 << b);
      t = 2 * c - 1;
      if (t * t <= q) r = c;
    end
    return r[25:0];
  endfunction

  // Accumulate pass: sum the square, count the element, close the vector on last.
  function automatic void absorb_square(input logic [15:0] x, input logic last);
    logic [63:0] mag;
    logic [63:0] total;
    logic [63:0] mean;
    mag = x[15] ? (64'h10000 - 64'(x)) : 64'(x);
    if (n_elems < MAX_DIM) begin
      total = 64'(sum_sq) + mag * mag;
      sum_sq = (total > 64'hFFF_FFFF_FFFF) ? '1 : total[43:0];
      n_elems++;
    end
    if (last) begin
      mean = (n_elems != 0) ? 64'(sum_sq) / 64'(n_elems) : 64'd0;
      inv_rms = recip_root(mean + 64'(eps_reg));
      sum_sq = '0;
      n_elems = '0;
    end
  endfunction

  // Apply pass: y = x * inv_rms * w (or w + 1.0), round half away, saturate to Q4.11.
  function automatic logic [Y_W-1:0] normalize_sample(input logic [15:0] x,
                                                      input logic [15:0] w);
    logic [63:0]        xmag;
    logic [63:0]        wmag;
    logic [63:0]        p1;
    logic [63:0]        hi;
    logic [63:0]        lo;
    logic [63:0]        mag;
    logic signed [31:0] wv;
    logic               neg;
    xmag = x[15] ? (64'h10000 - 64'(x)) : 64'(x);
    wv = 32'(signed'(w));
    if (unit_off) wv = wv + 32'sd8192;
    wmag = (wv < 0) ? 64'(-wv) : 64'(wv);
    neg = x[15] != (wv < 0);
    p1 = xmag * 64'(inv_rms);
    hi = (p1 >> 32) * wmag;
    lo = {32'd0, p1[31:0]} * wmag;
    mag = (hi << 3) + ((lo + (64'd1 << 28)) >> 29);
    if (neg) begin
      if (mag > 64'd32768) mag = 64'd32768;
      mag = 64'd0 - mag;
    end else if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return mag[Y_W-1:0];
  endfunction

  function automatic logic [15:0] pick_sample();
    logic [15:0] corners[5];
    corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
    case ($urandom_range(9))
      0:       return corners[$urandom_range(4)];
      1, 2:    return $urandom_range(1) ? 16'($urandom_range(255)) : -16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    logic [15:0] corners[6];
    corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'h2000, 16'hE000, 16'hFFFF};
    return ($urandom_range(7) == 0) ? corners[$urandom_range(5)] : 16'($urandom);
  endfunction

  function automatic logic [29:0] pick_eps();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return 30'($urandom_range(64));
      3:       return 30'($urandom);
      default: return EPS_RESET;
    endcase
  endfunction

  function automatic plan_row_t beat_row(input logic cmd, input logic [15:0] x,
                                         input logic [15:0] w, input logic last,
                                         input logic pinned, input logic [Y_W-1:0] y);
    plan_row_t row;
    row = '0;
    row.cmd = cmd;
    row.x = x;
    row.w = w;
    row.last = last;
    row.pinned = pinned;
    row.pinned_y = y;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // Offer one beat, with random idle cycles ahead of it, and hold it until taken.
  // Predict on acceptance; a pinned row overrides the predicted y.
  task automatic push_beat(input logic cmd, input logic [15:0] x, input logic [15:0] w,
                           input logic last, input logic pinned,
                           input logic [Y_W-1:0] pinned_y);
    norm_beat_t want;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {w, x};
    s_tuser  <= cmd;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
    if (cmd == CMD_APPLY) begin
      want.y = pinned ? pinned_y : normalize_sample(x, w);
      want.last = last;
      pending_y.push_back(want);
    end else begin
      absorb_square(x, last);
    end
  endtask

  // Drop valid and wait until every queued result has come back.
  task automatic wait_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_y.size() != 0);
  endtask

  // Go fully idle: results back, then room for a trailing accumulate-last beat.
  task automatic settle_block();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == CFG_EPSILON) eps_reg = val;
    else unit_off = val[0];
    reg_writes++;
  endtask

  // One vector: accumulate pass, then apply pass; sometimes the apply pass
  // runs short or long with fresh samples past the end.
  task automatic run_vector();
    logic [15:0] xs[$];
    int n;
    int m;
    int r;
    r = $urandom_range(99);
    n = (r < 80) ? 1 + $urandom_range(11) :
        (r < 95) ? 13 + $urandom_range(35) : 49 + $urandom_range(151);
    for (int i = 0; i < n; i++) begin
      xs.push_back(pick_sample());
      push_beat(CMD_ACCUM, xs[i], 16'($urandom), i == n - 1, 1'b0, '0);
    end
    m = ($urandom_range(9) == 0) ? 1 + $urandom_range(n + 2) : n;
    for (int i = 0; i < m; i++)
      push_beat(CMD_APPLY, (i < n) ? xs[i] : pick_sample(), pick_weight(), i == m - 1,
                1'b0, '0);
    vectors_done++;
  endtask

  // Compare every taken output beat against the oldest prediction; stall at random.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_y.size() == 0) begin
        $display("%0t: unexpected beat y=%h last=%b", $time, m_tdata, m_tlast);
        errors++;
      end else begin
        seen_want = pending_y.pop_front();
        if (m_tdata !== seen_want.y) begin
          $display("%0t: y mismatch expected %h actual %h", $time, seen_want.y, m_tdata);
          errors++;
        end
        if (m_tlast !== seen_want.last) begin
          $display("%0t: last mismatch expected %b actual %b", $time, seen_want.last,
                   m_tlast);
          errors++;
        end
        beats_checked++;
      end
    end
  end

  initial begin
    int budget;
    int phase_end;
    int r;

    // Directed table. Reset leaves inverse rms at zero, so early applies give 0.
    plan.push_back(beat_row(CMD_APPLY, 16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 16'h0000));
    plan.push_back(beat_row(CMD_APPLY, 16'h8000, 16'h8000, 1'b1, 1'b1, 16'h0000));
    // A single zero sample with epsilon 4 saturates inverse rms: 1.0 * 1.0 clips.
    plan.push_back(beat_row(CMD_ACCUM, 16'h0000, 16'h1234, 1'b1, 1'b0, '0));
    plan.push_back(beat_row(CMD_APPLY, 16'h0800, 16'h2000, 1'b0, 1'b1, 16'h7FFF));
    plan.push_back(beat_row(CMD_APPLY, 16'hF800, 16'h2000, 1'b1, 1'b1, 16'h8000));
    plan.push_back(beat_row(CMD_APPLY, 16'h0000, 16'h7FFF, 1'b1, 1'b1, 16'h0000));
    // Extremes through a normal vector.
    plan.push_back(beat_row(CMD_ACCUM, 16'h7FFF, 16'hFFFF, 1'b0, 1'b0, '0));
    plan.push_back(beat_row(CMD_ACCUM, 16'h8000, 16'h0000, 1'b0, 1'b0, '0));
    plan.push_back(beat_row(CMD_ACCUM, 16'h0001, 16'h8000, 1'b0, 1'b0, '0));
    plan.push_back(beat_row(CMD_ACCUM, 16'hFFFF, 16'h7FFF, 1'b1, 1'b0, '0));
    plan.push_back(beat_row(CMD_APPLY, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, '0));
    plan.push_back(beat_row(CMD_APPLY, 16'h8000, 16'h8000, 1'b0, 1'b0, '0));
    plan.push_back(beat_row(CMD_APPLY, 16'h0001, 16'h0000, 1'b0, 1'b0, '0));
    plan.push_back(beat_row(CMD_APPLY, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0));
    // Zero mean square with zero epsilon saturates inverse rms.
    plan.push_back(cfg_row(CFG_EPSILON, '0));
    plan.push_back(beat_row(CMD_ACCUM, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
    plan.push_back(beat_row(CMD_ACCUM, 16'h0000, 16'h0000, 1'b1, 1'b0, '0));
    plan.push_back(beat_row(CMD_APPLY, 16'h0800, 16'h2000, 1'b1, 1'b1, 16'h7FFF));
    // Unit offset: -1.0 cancels to zero, the most negative weight clips low.
    plan.push_back(cfg_row(CFG_UNIT_OFFSET, 30'd1));
    plan.push_back(beat_row(CMD_APPLY, 16'h0800, 16'hE000, 1'b0, 1'b1, 16'h0000));
    plan.push_back(beat_row(CMD_APPLY, 16'h0800, 16'h8000, 1'b1, 1'b1, 16'h8000));
    // Largest epsilon.
    plan.push_back(cfg_row(CFG_EPSILON, '1));
    plan.push_back(beat_row(CMD_ACCUM, 16'h7FFF, 16'h0000, 1'b0, 1'b0, '0));
    plan.push_back(beat_row(CMD_ACCUM, 16'h8000, 16'h0000, 1'b1, 1'b0, '0));
    plan.push_back(beat_row(CMD_APPLY, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, '0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle_block();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        push_beat(plan[i].cmd, plan[i].x, plan[i].w, plan[i].last, plan[i].pinned,
                  plan[i].pinned_y);
      end
    end

    // Random part: sender idles lightly and receiver heavily, then the reverse,
    // then both run flat out. Change registers between phases only.
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 84 : 0;
      rx_idle_pct = (mode == 0) ? 84 : (mode == 1) ? 7 : 0;
      budget = beats_sent + MODE_BEATS;
      while (beats_sent < budget) begin
        settle_block();
        write_reg(CFG_EPSILON, pick_eps());
        write_reg(CFG_UNIT_OFFSET, 30'($urandom_range(1)));
        phase_end = beats_sent + 100 + $urandom_range(100);
        while (beats_sent < phase_end && beats_sent < budget) begin
          r = $urandom_range(99);
          if (r < 5) begin
            // Hold off until the output side has caught up.
            wait_results();
          end else if (r < 20) begin
            // Noise: loose beats of any kind, possibly breaking a vector.
            repeat (1 + $urandom_range(5))
              push_beat(1'($urandom_range(1)), pick_sample(), pick_weight(),
                        $urandom_range(3) == 0, 1'b0, '0);
          end else begin
            run_vector();
          end
        end
      end
    end

    settle_block();
    $display("Covered %0d input beats and %0d vectors, %0d register writes,", beats_sent,
             vectors_done, reg_writes);
    $display("checked %0d output beats under three idle patterns.", beats_checked);
    if (errors == 0 && pending_y.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
